[rtl/core/voxel_line_of_sight_3d_macros.svh]
// Assertion macros for the voxel line-of-sight block.
`ifndef VOXEL_LINE_OF_SIGHT_3D_MACROS_SVH
`define VOXEL_LINE_OF_SIGHT_3D_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define VLOS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define VLOS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vlos_pkg.sv]
`timescale 1ns / 1ps

package vlos_pkg;

  localparam int CW        = 5;
  localparam int DIST_W    = 12;
  localparam int CFG_IDX_W = 1;

  typedef logic [CW-1:0]        coord_t;
  typedef logic [2:0][CW-1:0]   vec_t;
  typedef logic signed [7:0]    err_t;
  typedef logic [1:0]           axis_t;
  typedef logic [DIST_W-1:0]    dist_t;

  typedef struct packed {
    axis_t drv;
    axis_t m1;
    axis_t m2;
  } axes_t;

  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NEAR      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 1'd1;

endpackage

[rtl/core/voxel_line_of_sight_3d.sv]
`timescale 1ns / 1ps

// Voxel line-of-sight engine. A transaction is taken when start is high and busy is low.
// A write (cmd 0) inside the grid updates one occupancy cell in that cycle and produces no result.
// A query (cmd 1) runs a distance multiply-accumulate over the three axes on one shared 5x5
// multiplier, takes a decision step, then sends one voxel per cycle through the shared
// Bresenham stepper, whose next voxel is checked against the occupancy map by a registered
// map read. A range rejection or a near shortcut ends the query at the decision step; a
// blocked line ends as soon as an occupied or out-of-grid cell is reached.
// Results come one per cycle with out_valid high
// for exactly one cycle; the receiver cannot stall them, so it must take every strobe.
// The verdict (out_last) always closes a query. After reset the block stays busy while
// it clears all min(GRID_SIDE,32)^3 cells of the occupancy map one cell per cycle.
// cfg_ready is always high; write configuration only while busy is low.
module voxel_line_of_sight_3d #(
  parameter int GRID_SIDE = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic [4:0]                          in_start_x,
  input  logic [4:0]                          in_start_y,
  input  logic [4:0]                          in_start_z,
  input  logic [4:0]                          in_end_x,
  input  logic [4:0]                          in_end_y,
  input  logic [4:0]                          in_end_z,
  input  logic                                in_cell_occupied,
  input  logic                                in_range_limit_on,
  output logic                                out_valid,
  output logic [4:0]                          out_voxel_x,
  output logic [4:0]                          out_voxel_y,
  output logic [4:0]                          out_voxel_z,
  output logic                                out_is_voxel,
  output logic                                out_line_clear,
  output logic [4:0]                          out_visited_count,
  output logic                                out_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vlos_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [11:0]                         cfg_data
);

  localparam int ES    = (GRID_SIDE > 32) ? 32 : GRID_SIDE;
  localparam int DEPTH = ES * ES * ES;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_DIST   = 5'b00100,
    ST_DECIDE = 5'b01000,
    ST_STEP   = 5'b10000
  } state_t;

  function automatic logic [AW-1:0] cell_idx(vlos_pkg::vec_t c);
    logic [15:0] w;
    w = 16'(c[0]) + 16'(ES) * (16'(c[1]) + 16'(ES) * 16'(c[2]));
    return w[AW-1:0];
  endfunction

  function automatic logic in_grid(vlos_pkg::vec_t c);
    return ({1'b0, c[0]} < 6'(ES)) && ({1'b0, c[1]} < 6'(ES)) &&
           ({1'b0, c[2]} < 6'(ES));
  endfunction

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  vlos_pkg::dist_t      near_r, near_nxt;
  vlos_pkg::dist_t      maxr_r, maxr_nxt;
  vlos_pkg::vec_t       p_r, p_nxt;
  vlos_pkg::vec_t       d_r, d_nxt;
  logic [2:0]           neg_r, neg_nxt;
  logic                 rng_r, rng_nxt;
  vlos_pkg::axis_t      k_r, k_nxt;
  vlos_pkg::dist_t      acc_r, acc_nxt;
  vlos_pkg::axes_t      ax_r, ax_nxt;
  vlos_pkg::err_t       err1_r, err1_nxt;
  vlos_pkg::err_t       err2_r, err2_nxt;
  vlos_pkg::coord_t     rem_r, rem_nxt;
  vlos_pkg::coord_t     cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic                 oob_r, oob_nxt;

  logic                 ov_r, ov_nxt;
  vlos_pkg::vec_t       ovox_r, ovox_nxt;
  logic                 oisv_r, oisv_nxt;
  logic                 oclr_r, oclr_nxt;
  vlos_pkg::coord_t     ocnt_r, ocnt_nxt;
  logic                 olast_r, olast_nxt;

  vlos_pkg::vec_t       in_p;
  vlos_pkg::vec_t       in_e;
  logic                 accept;
  vlos_pkg::vec_t       p_step;
  vlos_pkg::err_t       e1_step;
  vlos_pkg::err_t       e2_step;
  vlos_pkg::axes_t      ax_sel;
  vlos_pkg::coord_t     dk;
  logic [9:0]           sq;
  logic                 blocked;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic                 ram_wdata;
  logic                 ram_rdata;

  assign in_p      = {in_start_z, in_start_y, in_start_x};
  assign in_e      = {in_end_z, in_end_y, in_end_x};
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  vlos_step u_step (
    .p        (p_r),
    .d        (d_r),
    .neg      (neg_r),
    .ax       (ax_r),
    .err1     (err1_r),
    .err2     (err2_r),
    .p_nxt    (p_step),
    .err1_nxt (e1_step),
    .err2_nxt (e2_step)
  );

  vlos_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_idx(p_step)),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = accept && (in_cmd == vlos_pkg::CMD_WRITE) && in_grid(in_p);
      ram_waddr = cell_idx(in_p);
      ram_wdata = in_cell_occupied;
    end
  end

  always_comb begin
    if ((d_r[0] >= d_r[1]) && (d_r[0] >= d_r[2])) begin
      ax_sel = '{drv: vlos_pkg::AX_X, m1: vlos_pkg::AX_Y, m2: vlos_pkg::AX_Z};
    end else if ((d_r[1] >= d_r[0]) && (d_r[1] >= d_r[2])) begin
      ax_sel = '{drv: vlos_pkg::AX_Y, m1: vlos_pkg::AX_X, m2: vlos_pkg::AX_Z};
    end else begin
      ax_sel = '{drv: vlos_pkg::AX_Z, m1: vlos_pkg::AX_Y, m2: vlos_pkg::AX_X};
    end
    dk      = d_r[k_r];
    sq      = 10'(dk) * 10'(dk);
    blocked = pend_r && (oob_r || ram_rdata);
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    near_nxt  = near_r;
    maxr_nxt  = maxr_r;
    p_nxt     = p_r;
    d_nxt     = d_r;
    neg_nxt   = neg_r;
    rng_nxt   = rng_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    ax_nxt    = ax_r;
    err1_nxt  = err1_r;
    err2_nxt  = err2_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    oob_nxt   = oob_r;
    ov_nxt    = 1'b0;
    ovox_nxt  = '0;
    oisv_nxt  = 1'b0;
    oclr_nxt  = 1'b0;
    ocnt_nxt  = '0;
    olast_nxt = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vlos_pkg::REG_NEAR:      near_nxt = cfg_data;
        vlos_pkg::REG_MAX_RANGE: maxr_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (accept && (in_cmd == vlos_pkg::CMD_QUERY)) begin
          p_nxt   = in_p;
          rng_nxt = in_range_limit_on;
          for (int i = 0; i < 3; i++) begin
            neg_nxt[i] = !(in_e[i] > in_p[i]);
            d_nxt[i]   = (in_e[i] > in_p[i]) ? in_e[i] - in_p[i] : in_p[i] - in_e[i];
          end
          k_nxt     = vlos_pkg::AX_X;
          acc_nxt   = '0;
          state_nxt = ST_DIST;
        end
      end
      ST_DIST: begin
        acc_nxt = acc_r + vlos_pkg::dist_t'(sq);
        if (k_r == vlos_pkg::AX_Z) begin
          state_nxt = ST_DECIDE;
        end else begin
          k_nxt = k_r + vlos_pkg::axis_t'(1);
        end
      end
      ST_DECIDE: begin
        if (rng_r && (acc_r >= maxr_r)) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else if (acc_r <= near_r) begin
          ov_nxt    = 1'b1;
          oclr_nxt  = 1'b1;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ax_nxt    = ax_sel;
          err1_nxt  = $signed({2'b00, d_r[ax_sel.m1], 1'b0}) -
                      $signed({3'b000, d_r[ax_sel.drv]});
          err2_nxt  = $signed({2'b00, d_r[ax_sel.m2], 1'b0}) -
                      $signed({3'b000, d_r[ax_sel.drv]});
          rem_nxt   = d_r[ax_sel.drv];
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (blocked) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          if (pend_r) begin
            ov_nxt   = 1'b1;
            ovox_nxt = p_r;
            oisv_nxt = 1'b1;
            cnt_nxt  = cnt_r + vlos_pkg::coord_t'(1);
          end
          if (rem_r != '0) begin
            p_nxt    = p_step;
            err1_nxt = e1_step;
            err2_nxt = e2_step;
            rem_nxt  = rem_r - vlos_pkg::coord_t'(1);
            pend_nxt = 1'b1;
            oob_nxt  = !in_grid(p_step);
          end else begin
            pend_nxt = 1'b0;
            if (!pend_r) begin
              ov_nxt    = 1'b1;
              oclr_nxt  = 1'b1;
              ocnt_nxt  = cnt_r;
              olast_nxt = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      near_r  <= vlos_pkg::dist_t'(3);
      maxr_r  <= vlos_pkg::dist_t'(4095);
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      near_r  <= near_nxt;
      maxr_r  <= maxr_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r     <= p_nxt;
    d_r     <= d_nxt;
    neg_r   <= neg_nxt;
    rng_r   <= rng_nxt;
    k_r     <= k_nxt;
    acc_r   <= acc_nxt;
    ax_r    <= ax_nxt;
    err1_r  <= err1_nxt;
    err2_r  <= err2_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    oob_r   <= oob_nxt;
    ovox_r  <= ovox_nxt;
    oisv_r  <= oisv_nxt;
    oclr_r  <= oclr_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid         = ov_r;
  assign out_voxel_x       = ovox_r[0];
  assign out_voxel_y       = ovox_r[1];
  assign out_voxel_z       = ovox_r[2];
  assign out_is_voxel      = oisv_r;
  assign out_line_clear    = oclr_r;
  assign out_visited_count = ocnt_r;
  assign out_last          = olast_r;

`include "voxel_line_of_sight_3d_macros.svh"

  `VLOS_ASSERT_NXT(a_query_holds_busy, accept && (in_cmd == vlos_pkg::CMD_QUERY), busy, "query transaction did not raise busy")
  `VLOS_ASSERT_NXT(a_verdict_closes, out_valid && out_last, !out_valid, "result followed the verdict directly")
  `VLOS_ASSERT_IMP(a_voxel_while_busy, out_valid && out_is_voxel, busy && !out_last, "voxel result outside a running query")
  `VLOS_ASSERT_IMP(a_no_result_in_clear, state_r == ST_CLEAR, !out_valid && busy, "result or idle during map clear")

endmodule

[rtl/core/vlos_ram.sv]
`timescale 1ns / 1ps

module vlos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/vlos_step.sv]
`timescale 1ns / 1ps

// One Bresenham advance along the driving axis, with minor-axis error update.
module vlos_step (
  input  vlos_pkg::vec_t  p,
  input  vlos_pkg::vec_t  d,
  input  logic [2:0]      neg,
  input  vlos_pkg::axes_t ax,
  input  vlos_pkg::err_t  err1,
  input  vlos_pkg::err_t  err2,
  output vlos_pkg::vec_t  p_nxt,
  output vlos_pkg::err_t  err1_nxt,
  output vlos_pkg::err_t  err2_nxt
);

  function automatic vlos_pkg::coord_t adv(vlos_pkg::coord_t c, logic dn);
    return dn ? c - vlos_pkg::coord_t'(1) : c + vlos_pkg::coord_t'(1);
  endfunction

  logic signed [8:0] dd2;
  logic signed [8:0] dm1x2;
  logic signed [8:0] dm2x2;
  logic signed [8:0] t1;
  logic signed [8:0] t2;

  always_comb begin
    dd2   = $signed({3'b000, d[ax.drv], 1'b0});
    dm1x2 = $signed({3'b000, d[ax.m1], 1'b0});
    dm2x2 = $signed({3'b000, d[ax.m2], 1'b0});
    p_nxt = p;
    p_nxt[ax.drv] = adv(p[ax.drv], neg[ax.drv]);
    t1 = $signed({err1[7], err1}) + dm1x2;
    t2 = $signed({err2[7], err2}) + dm2x2;
    if (!err1[7]) begin
      p_nxt[ax.m1] = adv(p[ax.m1], neg[ax.m1]);
      t1 = t1 - dd2;
    end
    if (!err2[7]) begin
      p_nxt[ax.m2] = adv(p[ax.m2], neg[ax.m2]);
      t2 = t2 - dd2;
    end
    err1_nxt = t1[7:0];
    err2_nxt = t2[7:0];
  end

endmodule
